[rtl/core/cts_pkg.sv]
// Shared types and constant tables for the color tag substituter.
// Tag spellings, escape sequences and the command word passed from the
// classifier to the serializer. No dependencies.
package cts_pkg;

   localparam int TAG_COUNT  = 7;
   localparam int HOLD_DEPTH = 7;
   localparam int CMD_BYTES  = 8;
   localparam int ESC_MAX    = 5;

   localparam logic [7:0] ESC_CHAR   = 8'h1B;
   localparam logic [7:0] BRACE_CHAR = 8'h7B;

   // Tag spellings, zero padded to eight characters.
   localparam logic [7:0] TAG_CHARS [TAG_COUNT][CMD_BYTES] = '{
      '{"{", "r", "e", "d", "}", 8'h00, 8'h00, 8'h00},
      '{"{", "g", "r", "e", "e", "n", "}", 8'h00},
      '{"{", "y", "e", "l", "l", "o", "w", "}"},
      '{"{", "b", "l", "u", "e", "}", 8'h00, 8'h00},
      '{"{", "p", "u", "r", "p", "l", "e", "}"},
      '{"{", "c", "y", "a", "n", "}", 8'h00, 8'h00},
      '{"{", "e", "o", "c", "}", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] TAG_LEN [TAG_COUNT] = '{
      4'd5, 4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd5
   };

   localparam logic [7:0] ESC_CHARS [TAG_COUNT][ESC_MAX] = '{
      '{ESC_CHAR, "[", "3", "1", "m"},
      '{ESC_CHAR, "[", "3", "2", "m"},
      '{ESC_CHAR, "[", "3", "3", "m"},
      '{ESC_CHAR, "[", "9", "4", "m"},
      '{ESC_CHAR, "[", "3", "5", "m"},
      '{ESC_CHAR, "[", "9", "6", "m"},
      '{ESC_CHAR, "[", "0", "m", 8'h00}
   };

   localparam logic [2:0] ESC_LEN [TAG_COUNT] = '{
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4
   };

   // Up to eight output bytes caused by one input word.
   typedef struct packed {
      logic [CMD_BYTES-1:0][7:0] bytes;
      logic [3:0]                count;
      logic                      last;
   } cts_cmd_type;

   typedef struct packed {
      logic        valid;
      cts_cmd_type cmd;
   } cts_slot_type;

endpackage

[rtl/core/cts_req_if.sv]
// Input word channel of the color tag substituter: one text byte per word.
// Depends on nothing.
interface cts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/core/cts_rsp_if.sv]
// Output word channel of the color tag substituter: one emitted byte per word.
// Depends on nothing.
interface cts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       text_end;

   modport source (output valid, output out_byte, output run_end, output text_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_end, input text_end,
                 output ready);
endinterface

[rtl/core/cts_front.sv]
// Classifier: accepts text words, tracks the held tag prefix and turns each
// word into one command of 0 to 8 output bytes. Uses cts_pkg, cts_req_if.
module cts_front
   import cts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   cts_req_if.sink      req_chan,
   input  logic         q_full,
   output cts_slot_type push
);

   logic [7:0]           held_ff [HOLD_DEPTH];
   logic [2:0]           held_count_ff, held_count_in;
   logic [TAG_COUNT-1:0] cand_ff, cand_in;

   logic                 accept;
   logic [7:0]           b;
   logic                 last;
   logic [3:0]           next_len;
   logic [TAG_COUNT-1:0] ext_mask, full_mask;
   logic                 any_hit, full_hit;
   logic [2:0]           full_idx;
   logic [CMD_BYTES-1:0][7:0] lit;
   logic                 hold_brace;
   logic                 held_wr_en;
   logic [2:0]           held_wr_idx;
   cts_cmd_type          cmd;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b      = req_chan.text_byte;
   assign last   = req_chan.end_of_text;
   assign next_len = {1'b0, held_count_ff} + 4'd1;

   always_comb begin
      ext_mask  = '0;
      full_mask = '0;
      full_idx  = '0;
      for (int t = 0; t < TAG_COUNT; t++) begin
         ext_mask[t] = cand_ff[t] && (next_len <= TAG_LEN[t]) &&
                       (TAG_CHARS[t][held_count_ff] == b);
         full_mask[t] = ext_mask[t] && (next_len == TAG_LEN[t]);
         if (full_mask[t]) begin
            full_idx = 3'(t);
         end
      end
   end

   assign any_hit  = (held_count_ff != 3'd0) && (ext_mask != '0);
   assign full_hit = any_hit && (full_mask != '0);

   // Literal run: held bytes in order, then the arriving byte.
   always_comb begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         lit[i] = (3'(i) < held_count_ff) ? held_ff[i] : b;
      end
      lit[CMD_BYTES-1] = b;
   end

   assign hold_brace = (b == BRACE_CHAR) && !last;

   always_comb begin
      cmd           = '0;
      cmd.last      = last;
      held_count_in = 3'd0;
      cand_in       = cand_ff;
      held_wr_en    = 1'b0;
      held_wr_idx   = 3'd0;
      if (full_hit) begin
         for (int i = 0; i < ESC_MAX; i++) begin
            cmd.bytes[i] = ESC_CHARS[full_idx][i];
         end
         cmd.count = {1'b0, ESC_LEN[full_idx]};
      end else if (any_hit) begin
         if (last) begin
            cmd.bytes = lit;
            cmd.count = next_len;
         end else begin
            held_wr_en    = 1'b1;
            held_wr_idx   = held_count_ff;
            held_count_in = next_len[2:0];
            cand_in       = ext_mask;
         end
      end else begin
         cmd.bytes = lit;
         cmd.count = {1'b0, held_count_ff} + {3'd0, !hold_brace};
         if (hold_brace) begin
            held_wr_en    = 1'b1;
            held_count_in = 3'd1;
            cand_in       = '1;
         end
      end
   end

   assign push.valid = accept && (cmd.count != 4'd0);
   assign push.cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 3'd0;
         cand_ff       <= '0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         cand_ff       <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_wr_en) begin
         held_ff[held_wr_idx] <= b;
      end
   end

   a_held_has_candidate: assert property (@(posedge clock) disable iff (reset)
      (held_count_ff != 3'd0) |-> (cand_ff != '0))
      else $error("held prefix matches no tag");

   a_end_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_text) |=> (held_count_ff == 3'd0))
      else $error("bytes still held after end of text");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_text) |-> push.valid)
      else $error("end of text produced no command");

endmodule

[rtl/core/cts_queue.sv]
// Two-entry command queue between classifier and serializer.
// Uses cts_pkg.
module cts_queue
   import cts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cts_slot_type push,
   output logic         full,
   input  logic         pop,
   output cts_slot_type head
);

   cts_cmd_type entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != 2'd0);
   assign count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

[rtl/core/cts_back.sv]
// Serializer: walks the head command one byte per cycle into the output
// register while the receiver keeps up. Uses cts_pkg, cts_rsp_if.
module cts_back
   import cts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cts_slot_type head,
   output logic         pop,
   cts_rsp_if.source    rsp_chan
);

   logic [2:0] idx_ff;
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       run_end_ff, text_end_ff;
   logic       load;
   logic       last_word;

   assign load      = head.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign last_word = ({1'b0, idx_ff} == (head.cmd.count - 4'd1));
   assign pop       = load && last_word;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.run_end  = run_end_ff;
   assign rsp_chan.text_end = text_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= last_word ? 3'd0 : idx_ff + 3'd1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= head.cmd.bytes[idx_ff];
         run_end_ff  <= last_word;
         text_end_ff <= last_word && head.cmd.last;
      end
   end

   a_text_end_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && text_end_ff) |-> run_end_ff)
      else $error("text_end without run_end");

   a_index_advances: assert property (@(posedge clock) disable iff (reset)
      (load && !last_word) |=> (idx_ff == $past(idx_ff) + 3'd1))
      else $error("byte index did not advance");

   a_head_count_legal: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> ((head.cmd.count != 4'd0) && (head.cmd.count <= 4'd8)))
      else $error("queued command has illegal byte count");

endmodule

[rtl/core/color_tag_substituter_core.sv]
// Color tag substituter top level: classifier, command queue, serializer.
// Uses cts_pkg, cts_req_if, cts_rsp_if, cts_front, cts_queue, cts_back.
//
// Streams text one byte per word and replaces the tags {red}, {green},
// {yellow}, {blue}, {purple}, {cyan} and {eoc} by their ANSI color escape
// sequences; all other bytes pass through unchanged. From a '{' onward,
// bytes are held while they still spell the start of a tag; when a byte
// breaks the match, the held bytes go out literally and the byte is looked
// at afresh, so a '{' there opens a new candidate. A word with end_of_text
// set flushes whatever is held. Every output word carries run_end on the
// last byte caused by one input word, and text_end on the last byte caused
// by the word that closed the text. An input word yields 0 to 8 output
// bytes; a held byte yields none until the tag completes or breaks.
// Rate: the classifier takes one word per cycle while the two-entry
// command queue has room; the serializer drains one output byte per cycle
// while the receiver is ready, so a word that causes several bytes holds
// the back end until they are sent, and sustained throughput is one input
// word per cycle for plain text. An accepted word goes through the queue,
// then the output register. No clearing pass after reset is needed.
module color_tag_substituter_core
   import cts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cts_req_if.sink   req_chan,
   cts_rsp_if.source rsp_chan
);

   cts_slot_type push;
   cts_slot_type head;
   logic         q_full;
   logic         pop;

   // Classify each accepted word and advance the held tag prefix.
   cts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   // Hold up to two pending commands so either side can stall alone.
   cts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   // Drain the head command one byte per cycle, while the receiver is ready, through the output register.
   cts_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[bench/tb_top.sv]
// Self-checking bench for color_tag_substituter_core: scoreboard class with its own tag
// substitution predictor, paced word drivers and a stalling receiver.
// Depends on cts_req_if, cts_rsp_if and the core (which pulls in cts_pkg).
module tb_top;

   localparam logic [7:0] ESC_BYTE   = 8'h1B;
   localparam logic [7:0] OPEN_BRACE = 8'h7B;
   localparam int         HELD_MAX   = 7;
   localparam int         WORD_MAX   = 8;
   localparam int         NUM_TAGS   = 7;
   localparam int         TEXT_WORDS = 480;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         LONG_HOLD   = 400;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_end;
      logic       text_end;
   } out_word_type;

   // Predicts the bytes the core must emit and checks them in order.
   class tag_sub_scoreboard;
      string        tag_word [NUM_TAGS];
      string        esc_tail [NUM_TAGS];
      logic [7:0]   held_chars [HELD_MAX];
      int           held_count;
      out_word_type step_bytes [$];
      out_word_type expected_bytes [$];
      int           errors;

      function new();
         tag_word = '{"{red}", "{green}", "{yellow}", "{blue}", "{purple}", "{cyan}", "{eoc}"};
         esc_tail = '{"[31m", "[32m", "[33m", "[94m", "[35m", "[96m", "[0m"};
         foreach (held_chars[i]) held_chars[i] = 8'h00;
         held_count = 0;
         errors = 0;
      endfunction

      function void emit(logic [7:0] b);
         out_word_type w;
         if (step_bytes.size() < WORD_MAX) begin
            w.out_byte = b;
            w.run_end  = 1'b0;
            w.text_end = 1'b0;
            step_bytes.push_back(w);
         end
      endfunction

      function void flush_held();
         for (int i = 0; i < held_count; i++) emit(held_chars[i]);
         held_count = 0;
      endfunction

      // Does the held prefix plus b still spell the start of a tag?
      // full gets the completed tag, or -1.
      function bit extends_tag(logic [7:0] b, output int full);
         int  span;
         bit  any;
         bit  ok;
         span = held_count + 1;
         any  = 1'b0;
         full = -1;
         for (int t = 0; t < NUM_TAGS; t++) begin
            if (span > tag_word[t].len()) continue;
            ok = 1'b1;
            for (int i = 0; i < held_count; i++)
               if (8'(tag_word[t][i]) != held_chars[i]) ok = 1'b0;
            if (8'(tag_word[t][span-1]) != b) ok = 1'b0;
            if (ok) begin
               any = 1'b1;
               if (span == tag_word[t].len()) full = t;
            end
         end
         return any;
      endfunction

      function void note_text_byte(logic [7:0] b, logic last);
         int full;
         bit taken;
         step_bytes.delete();
         taken = 1'b0;
         if (held_count > 0) begin
            if (extends_tag(b, full)) begin
               taken = 1'b1;
               if (full >= 0) begin
                  emit(ESC_BYTE);
                  for (int i = 0; i < esc_tail[full].len(); i++) emit(8'(esc_tail[full][i]));
                  held_count = 0;
               end else if (held_count < HELD_MAX) begin
                  held_chars[held_count] = b;
                  held_count++;
               end
            end else begin
               flush_held();
            end
         end
         if (!taken) begin
            if (b == OPEN_BRACE) begin
               held_chars[0] = b;
               held_count = 1;
            end else begin
               emit(b);
            end
         end
         if (last) flush_held();
         if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size()-1].run_end  = 1'b1;
            step_bytes[step_bytes.size()-1].text_end = last;
         end
         foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      endfunction

      function void check_out_byte(logic [7:0] ob, logic re, logic te);
         out_word_type w;
         if (expected_bytes.size() == 0) begin
            $error("unexpected output word: out_byte=%h run_end=%b text_end=%b", ob, re, te);
            errors++;
            return;
         end
         w = expected_bytes.pop_front();
         if (ob !== w.out_byte) begin
            $error("out_byte: expected %h, got %h", w.out_byte, ob);
            errors++;
         end
         if (re !== w.run_end) begin
            $error("run_end: expected %b, got %b", w.run_end, re);
            errors++;
         end
         if (te !== w.text_end) begin
            $error("text_end: expected %b, got %b", w.text_end, te);
            errors++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   words_sent;
   int   burst_left;
   bit   long_hold_req;
   int   hold_left;

   cts_req_if req_bus ();
   cts_rsp_if rsp_bus ();

   tag_sub_scoreboard sb;

   color_tag_substituter_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drive every input to a known value before the first edge.
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.text_byte   = 8'h00;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      long_hold_req       = 1'b0;
      hold_left           = 0;
      cycles              = 0;
      sb                  = new();
   end

   // Check output words before noting the input word of the same edge.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_out_byte(rsp_bus.out_byte, rsp_bus.run_end, rsp_bus.text_end);
         if (req_bus.valid && req_bus.ready)
            sb.note_text_byte(req_bus.text_byte, req_bus.end_of_text);
      end
   end

   // Receiver: switch between always ready, a fixed bit pattern and random
   // stalls; honor a long hold-off on request.
   initial begin : receiver
      int         mode;
      int         phase;
      logic [7:0] pattern;
      mode    = 0;
      phase   = 0;
      pattern = 8'hFF;
      forever begin
         @(negedge clock);
         if (phase % 50 == 0) begin
            mode    = $urandom_range(0, 2);
            pattern = 8'($urandom);
         end
         phase++;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (mode == 0) begin
            rsp_bus.ready = 1'b1;
         end else if (mode == 1) begin
            rsp_bus.ready = pattern[phase % 8];
         end else begin
            rsp_bus.ready = ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Offer one word at the falling edge and hold it until a rising edge accepts it.
   task automatic send_word(logic [7:0] b, logic last);
      @(negedge clock);
      req_bus.valid       = 1'b1;
      req_bus.text_byte   = b;
      req_bus.end_of_text = last;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   // Pace the sender in bursts; drop valid for a random gap between them.
   task automatic offer_word(logic [7:0] b, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_word(b, last);
   endtask

   task automatic offer_text(string s, bit end_last);
      for (int i = 0; i < s.len(); i++)
         offer_word(8'(s[i]), end_last && (i == s.len() - 1));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One random chunk: whole tags, broken prefixes, plain bytes, or a
   // prefix cut short by the end of text.
   task automatic offer_random_chunk();
      int    kind;
      int    t;
      int    cut;
      int    n;
      string tag;
      kind = $urandom_range(0, 9);
      t    = $urandom_range(0, NUM_TAGS - 1);
      tag  = sb.tag_word[t];
      if (kind <= 3) begin
         for (int i = 0; i < tag.len(); i++)
            offer_word(8'(tag[i]), (i == tag.len() - 1) && ($urandom_range(0, 7) == 0));
      end else if (kind <= 5) begin
         cut = $urandom_range(1, tag.len() - 1);
         for (int i = 0; i < cut; i++) offer_word(8'(tag[i]), 1'b0);
         offer_word(8'($urandom), $urandom_range(0, 7) == 0);
      end else if (kind <= 8) begin
         n = $urandom_range(1, 4);
         repeat (n) offer_word(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
         cut = $urandom_range(1, tag.len() - 1);
         for (int i = 0; i < cut; i++) offer_word(8'(tag[i]), i == cut - 1);
      end
   endtask

   initial begin : stimulus
      bit did_hold;
      bit did_drain;
      words_sent = 0;
      burst_left = 0;
      did_hold   = 1'b0;
      did_drain  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: byte extremes, a brace inside a broken prefix, text after
      // a tag, the longest hold flushed at end of text, a lone brace at end.
      offer_word(8'h00, 1'b0);
      offer_word(8'hFF, 1'b1);
      offer_text("{re{red}", 1'b0);
      offer_text("{eoc}x", 1'b0);
      offer_text("{yellow", 1'b1);
      offer_text("{{", 1'b1);

      while (words_sent < TEXT_WORDS) begin
         offer_random_chunk();
         // Hold the receiver off while the sender keeps offering words.
         if (!did_hold && words_sent > 150) begin
            did_hold      = 1'b1;
            long_hold_req = 1'b1;
         end
         // Pause the sender until every expected byte has come out.
         if (!did_drain && words_sent > 300) begin
            did_drain = 1'b1;
            wait_drained();
         end
      end
      // Close the text so nothing stays held.
      offer_word(8'h2E, 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
